// ===== src/rcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcp_pkg: shared definitions for the random-carrier three-phase PWM
// Widths, reset values, register indexes, state codes and the control
// structs passed between the sequencer, divider and compare lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package rcp_pkg;

  // Field widths.
  localparam int VOLT_W     = 16;
  localparam int PER_W      = 16;
  localparam int CMP_W      = 17;
  localparam int BASE_W     = 17;
  localparam int SPAN_W     = 16;
  localparam int PSC_W      = 17;
  localparam int CLK_W      = 28;
  localparam int CFG_DATA_W = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int RNG_W      = 32;

  // Divider widths: remainder and divisor hold the scaled carrier, the
  // shift register holds the first quotient, which does not exceed the clock value.
  localparam int REM_W = 49;
  localparam int QUO_W = 28;
  localparam int CNT_W = 5;

  // Number of steps (minus one) of each divider pass.
  localparam logic [CNT_W-1:0] DIV1_LAST = 5'd27;
  localparam logic [CNT_W-1:0] DIV2_LAST = 5'd15;

  // Register reset values.
  localparam logic [BASE_W-1:0] BASE_RST = 17'd10000;
  localparam logic [SPAN_W-1:0] SPAN_RST = 16'd0;
  localparam logic [PSC_W-1:0]  PSC_RST  = 17'd1;
  localparam logic [CLK_W-1:0]  CLK_RST  = 28'd72000000;

  // Generator seed and shift amounts.
  localparam logic [RNG_W-1:0] RNG_X_RST = 32'd123456789;
  localparam logic [RNG_W-1:0] RNG_Y_RST = 32'd362436069;
  localparam logic [RNG_W-1:0] RNG_Z_RST = 32'd521288629;
  localparam logic [RNG_W-1:0] RNG_W_RST = 32'd88675123;
  localparam int XS_A = 11;
  localparam int XS_B = 19;
  localparam int XS_C = 8;

  // Voltage limits in Q2.14.
  localparam logic signed [VOLT_W-1:0] VOLT_MAX = 16'sd16384;
  localparam logic signed [VOLT_W-1:0] VOLT_MIN = -16'sd16384;
  localparam logic [VOLT_W-1:0]        VOLT_OFS = 16'd16384;
  localparam logic [VOLT_W-1:0]        OFS_MAX  = 16'd32768;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE = 3'd0,
    CFG_SPAN = 3'd1,
    CFG_PSC  = 3'd2,
    CFG_CLK  = 3'd3
  } rcp_cfg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CAR,
    S_DIV1,
    S_PSC,
    S_DIV2,
    S_LANE,
    S_DONE
  } rcp_state_e;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } rcp_div_stat_t;

  // Compare lane control.
  typedef struct packed {
    logic load;
    logic calc;
  } rcp_lane_ctrl_t;

endpackage

`default_nettype wire

// ===== src/rcp_in_if.sv =====
// ----------------------------------------------------------------------------
// rcp_in_if: update channel
// Carries one beat of three phase voltage references.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rcp_pkg::VOLT_W-1:0]   volt_u;
  logic signed [rcp_pkg::VOLT_W-1:0]   volt_v;
  logic signed [rcp_pkg::VOLT_W-1:0]   volt_w;

  modport source (output valid, output volt_u, output volt_v, output volt_w, input ready);
  modport sink   (input valid, input volt_u, input volt_v, input volt_w, output ready);
endinterface

`default_nettype wire

// ===== src/rcp_out_if.sv =====
// ----------------------------------------------------------------------------
// rcp_out_if: timer setting channel
// Carries one beat of period count, three compare values and a flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcp_out_if;
  logic                         valid;
  logic                         ready;
  logic [rcp_pkg::PER_W-1:0]    period_count;
  logic [rcp_pkg::CMP_W-1:0]    compare_u;
  logic [rcp_pkg::CMP_W-1:0]    compare_v;
  logic [rcp_pkg::CMP_W-1:0]    compare_w;
  logic                         period_saturated;

  modport source (output valid, output period_count, output compare_u, output compare_v,
                  output compare_w, output period_saturated, input ready);
  modport sink   (input valid, input period_count, input compare_u, input compare_v,
                  input compare_w, input period_saturated, output ready);
endinterface

`default_nettype wire

// ===== src/rcp_div.sv =====
// ----------------------------------------------------------------------------
// rcp_div: serial restoring divider
// Shifts one dividend bit into the partial remainder per cycle and shifts
// one quotient bit out. The caller preloads remainder, divisor and the
// remaining dividend bits, and the number of steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rcp_pkg::REM_W-1:0]     rem_i,
  input  wire logic [rcp_pkg::REM_W-1:0]     divisor_i,
  input  wire logic [rcp_pkg::QUO_W-1:0]     shift_i,
  input  wire logic [rcp_pkg::CNT_W-1:0]     last_i,
  output rcp_pkg::rcp_div_stat_t             stat_o,
  output logic [rcp_pkg::QUO_W-1:0]          quot_o
);

  logic [rcp_pkg::REM_W-1:0] rem_q, rem_d;
  logic [rcp_pkg::REM_W-1:0] dvs_q;
  logic [rcp_pkg::QUO_W-1:0] sh_q, sh_d;
  logic [rcp_pkg::CNT_W-1:0] cnt_q;
  logic                      busy_q;
  logic [rcp_pkg::REM_W:0]   trial;
  logic [rcp_pkg::REM_W:0]   diff;
  logic                      ge;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_q, sh_q[rcp_pkg::QUO_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[rcp_pkg::REM_W-1:0] : trial[rcp_pkg::REM_W-1:0];
    sh_d  = {sh_q[rcp_pkg::QUO_W-2:0], ge};
  end

  // Control: busy flag and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= last_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      dvs_q <= divisor_i;
      sh_q  <= shift_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == '0);
  assign quot_o      = sh_q;

`ifndef ASSERT_OFF
  // The partial remainder always stays below the divisor while stepping.
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== src/rcp_lane.sv =====
// ----------------------------------------------------------------------------
// rcp_lane: compare value lane for one phase
// Clamps the phase voltage to +-1.0 when the beat arrives, then forms
// floor((period + 1) * (1 + v) / 2) once the period is known.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_lane (
  input  wire logic                                clk_i,
  input  wire rcp_pkg::rcp_lane_ctrl_t             ctrl_i,
  input  wire logic signed [rcp_pkg::VOLT_W-1:0]   volt_i,
  input  wire logic [rcp_pkg::PER_W-1:0]           period_i,
  output logic [rcp_pkg::CMP_W-1:0]                cmp_o
);

  logic [rcp_pkg::VOLT_W-1:0]              ofs_q, ofs_d;
  logic [rcp_pkg::CMP_W-1:0]               cmp_q;
  logic [rcp_pkg::PER_W:0]                 per1;
  logic [rcp_pkg::PER_W+rcp_pkg::VOLT_W:0] prod;

  // Clamp and shift the voltage into the range 0 .. 2.0.
  always_comb begin
    if (volt_i > rcp_pkg::VOLT_MAX) begin
      ofs_d = rcp_pkg::OFS_MAX;
    end else if (volt_i < rcp_pkg::VOLT_MIN) begin
      ofs_d = '0;
    end else begin
      ofs_d = $unsigned(volt_i) + rcp_pkg::VOLT_OFS;
    end
  end

  // Scale the period by the duty and drop the fraction.
  assign per1 = {1'b0, period_i} + 1'b1;
  assign prod = per1 * ofs_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ofs_q <= ofs_d;
    end
    if (ctrl_i.calc) begin
      cmp_q <= prod[rcp_pkg::CMP_W+14:15];
    end
  end

  assign cmp_o = cmp_q;

endmodule

`default_nettype wire

// ===== src/rcp_merge.sv =====
// ----------------------------------------------------------------------------
// rcp_merge: result merge and output register
// Combines the period and the three lane compare values into one beat and
// holds it until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_merge (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic [rcp_pkg::PER_W-1:0]   period_i,
  input  wire logic                        sat_i,
  input  wire logic [rcp_pkg::CMP_W-1:0]   cmp_u_i,
  input  wire logic [rcp_pkg::CMP_W-1:0]   cmp_v_i,
  input  wire logic [rcp_pkg::CMP_W-1:0]   cmp_w_i,
  output logic                             space_o,
  rcp_out_if.source                        out_o
);

  logic                      valid_q;
  logic [rcp_pkg::PER_W-1:0] period_q;
  logic                      sat_q;
  logic [rcp_pkg::CMP_W-1:0] cmp_u_q;
  logic [rcp_pkg::CMP_W-1:0] cmp_v_q;
  logic [rcp_pkg::CMP_W-1:0] cmp_w_q;

  // The register can take a new beat when empty or being drained.
  assign space_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      period_q <= period_i;
      sat_q    <= sat_i;
      cmp_u_q  <= cmp_u_i;
      cmp_v_q  <= cmp_v_i;
      cmp_w_q  <= cmp_w_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.period_count     = period_q;
  assign out_o.period_saturated = sat_q;
  assign out_o.compare_u        = cmp_u_q;
  assign out_o.compare_v        = cmp_v_q;
  assign out_o.compare_w        = cmp_w_q;

endmodule

`default_nettype wire

// ===== src/random_carrier_three_phase_pwm.sv =====
// ----------------------------------------------------------------------------
// Processing: each accepted update beat runs through the shared serial divider
// (28 steps for the carrier division, 16 for the prescaler division, which is
// skipped when the period saturates); a new beat is taken only once the result
// beat has been loaded into the output register.
// Reset: asynchronous, active low; configuration registers return to their
// defaults and the generator to its seed, with no clearing pass.
// ----------------------------------------------------------------------------
// random_carrier_three_phase_pwm: random-carrier three-phase PWM update
// Advances an xorshift128 generator per beat, forms a randomized carrier,
// divides it into a timer period and computes three phase compare values
// in parallel lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module random_carrier_three_phase_pwm (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rcp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [rcp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  rcp_in_if.sink                                   in_i,
  rcp_out_if.source                                out_o
);

  // Configuration registers.
  logic [rcp_pkg::BASE_W-1:0] base_q;
  logic [rcp_pkg::SPAN_W-1:0] span_q;
  logic [rcp_pkg::PSC_W-1:0]  psc_q;
  logic [rcp_pkg::CLK_W-1:0]  clk_hz_q;

  // Generator state.
  logic [rcp_pkg::RNG_W-1:0] rng_x_q, rng_y_q, rng_z_q, rng_w_q;
  logic [rcp_pkg::RNG_W-1:0] rng_t, rng_w_d;

  // Sequencer.
  rcp_pkg::rcp_state_e state_q, state_d;
  logic                accept;

  // Carrier and divider hookup.
  logic [rcp_pkg::SPAN_W+rcp_pkg::RNG_W-1:0] prod_q;
  logic signed [rcp_pkg::BASE_W:0]           car_ofs;
  logic [rcp_pkg::REM_W:0]                   car_raw;
  logic [rcp_pkg::REM_W-1:0]                 car_clamp;
  logic [rcp_pkg::PSC_W-1:0]                 psc_eff;
  logic [rcp_pkg::PSC_W:0]                   psc_dbl;
  logic                                      sat_now;
  logic                                      sat_q;
  logic                                      div_start;
  logic [rcp_pkg::REM_W-1:0]                 div_rem;
  logic [rcp_pkg::REM_W-1:0]                 div_dvs;
  logic [rcp_pkg::QUO_W-1:0]                 div_sh;
  logic [rcp_pkg::CNT_W-1:0]                 div_last;
  rcp_pkg::rcp_div_stat_t                    div_stat;
  logic [rcp_pkg::QUO_W-1:0]                 quot;
  logic [rcp_pkg::PER_W-1:0]                 period;

  // Lanes and merge.
  rcp_pkg::rcp_lane_ctrl_t    lane_ctrl;
  logic [rcp_pkg::CMP_W-1:0]  cmp_u, cmp_v, cmp_w;
  logic                       out_space;
  logic                       merge_load;

  assign accept = in_i.valid && in_i.ready;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= rcp_pkg::BASE_RST;
      span_q   <= rcp_pkg::SPAN_RST;
      psc_q    <= rcp_pkg::PSC_RST;
      clk_hz_q <= rcp_pkg::CLK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcp_pkg::CFG_BASE: base_q   <= cfg_data_i[rcp_pkg::BASE_W-1:0];
        rcp_pkg::CFG_SPAN: span_q   <= cfg_data_i[rcp_pkg::SPAN_W-1:0];
        rcp_pkg::CFG_PSC:  psc_q    <= cfg_data_i[rcp_pkg::PSC_W-1:0];
        rcp_pkg::CFG_CLK:  clk_hz_q <= cfg_data_i[rcp_pkg::CLK_W-1:0];
        default: ;
      endcase
    end
  end

  // The generator advances once per accepted beat.
  always_comb begin
    rng_t   = rng_x_q ^ (rng_x_q << rcp_pkg::XS_A);
    rng_w_d = rng_w_q ^ (rng_w_q >> rcp_pkg::XS_B) ^ rng_t ^ (rng_t >> rcp_pkg::XS_C);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_x_q <= rcp_pkg::RNG_X_RST;
      rng_y_q <= rcp_pkg::RNG_Y_RST;
      rng_z_q <= rcp_pkg::RNG_Z_RST;
      rng_w_q <= rcp_pkg::RNG_W_RST;
    end else if (accept) begin
      rng_x_q <= rng_y_q;
      rng_y_q <= rng_z_q;
      rng_z_q <= rng_w_q;
      rng_w_q <= rng_w_d;
    end
  end

  // Scaled carrier: (base - span) * 2^31 + span * w, at least 2^31 (1 Hz).
  assign car_ofs = $signed({1'b0, base_q}) - $signed({2'b0, span_q});
  assign car_raw = {car_ofs[rcp_pkg::BASE_W], car_ofs, 31'd0} + {2'b0, prod_q};
  always_comb begin
    if (car_raw[rcp_pkg::REM_W] || (car_raw[rcp_pkg::REM_W-1:31] == '0)) begin
      car_clamp = {{(rcp_pkg::REM_W-32){1'b0}}, 1'b1, 31'd0};
    end else begin
      car_clamp = car_raw[rcp_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rcp_pkg::S_MUL) begin
      prod_q <= span_q * rng_w_q;
    end
  end

  // Prescaler stage: divisor is twice the prescaler, zero taken as one.
  assign psc_eff = (psc_q == '0) ? {{(rcp_pkg::PSC_W-1){1'b0}}, 1'b1} : psc_q;
  assign psc_dbl = {psc_eff, 1'b0};
  assign sat_now = ({6'd0, quot[rcp_pkg::QUO_W-1:16]} >= psc_dbl);

  always_ff @(posedge clk_i) begin
    if (state_q == rcp_pkg::S_PSC) begin
      sat_q <= sat_now;
    end
  end

  assign period = sat_q ? {rcp_pkg::PER_W{1'b1}} : quot[rcp_pkg::PER_W-1:0];

  // Divider operands for the carrier pass and for the prescaler pass.
  always_comb begin
    if (state_q == rcp_pkg::S_CAR) begin
      div_rem  = {18'd0, clk_hz_q, 3'd0};
      div_dvs  = car_clamp;
      div_sh   = '0;
      div_last = rcp_pkg::DIV1_LAST;
    end else begin
      div_rem  = {37'd0, quot[rcp_pkg::QUO_W-1:16]};
      div_dvs  = {31'd0, psc_dbl};
      div_sh   = {quot[15:0], 12'd0};
      div_last = rcp_pkg::DIV2_LAST;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcp_pkg::S_IDLE: if (in_i.valid) state_d = rcp_pkg::S_MUL;
      rcp_pkg::S_MUL:  state_d = rcp_pkg::S_CAR;
      rcp_pkg::S_CAR:  state_d = rcp_pkg::S_DIV1;
      rcp_pkg::S_DIV1: if (div_stat.done) state_d = rcp_pkg::S_PSC;
      rcp_pkg::S_PSC:  state_d = sat_now ? rcp_pkg::S_LANE : rcp_pkg::S_DIV2;
      rcp_pkg::S_DIV2: if (div_stat.done) state_d = rcp_pkg::S_LANE;
      rcp_pkg::S_LANE: state_d = rcp_pkg::S_DONE;
      rcp_pkg::S_DONE: if (out_space) state_d = rcp_pkg::S_IDLE;
      default:         state_d = rcp_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_i.ready     = 1'b0;
    div_start      = 1'b0;
    lane_ctrl.load = 1'b0;
    lane_ctrl.calc = 1'b0;
    merge_load     = 1'b0;
    case (state_q)
      rcp_pkg::S_IDLE: begin
        in_i.ready     = 1'b1;
        lane_ctrl.load = in_i.valid;
      end
      rcp_pkg::S_CAR:  div_start      = 1'b1;
      rcp_pkg::S_PSC:  div_start      = !sat_now;
      rcp_pkg::S_LANE: lane_ctrl.calc = 1'b1;
      rcp_pkg::S_DONE: merge_load     = out_space;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared serial divider.
  rcp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem_i     (div_rem),
    .divisor_i (div_dvs),
    .shift_i   (div_sh),
    .last_i    (div_last),
    .stat_o    (div_stat),
    .quot_o    (quot)
  );

  // One compare lane per phase.
  rcp_lane u_lane_u (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .volt_i   (in_i.volt_u),
    .period_i (period),
    .cmp_o    (cmp_u)
  );

  rcp_lane u_lane_v (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .volt_i   (in_i.volt_v),
    .period_i (period),
    .cmp_o    (cmp_v)
  );

  rcp_lane u_lane_w (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .volt_i   (in_i.volt_w),
    .period_i (period),
    .cmp_o    (cmp_w)
  );

  // Merge the lanes into the result beat.
  rcp_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (merge_load),
    .period_i (period),
    .sat_i    (sat_q),
    .cmp_u_i  (cmp_u),
    .cmp_v_i  (cmp_v),
    .cmp_w_i  (cmp_w),
    .space_o  (out_space),
    .out_o    (out_o)
  );

`ifndef ASSERT_OFF
  // A saturated period is always reported as the full 16-bit count.
  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.period_saturated) |-> (out_o.period_count == 16'hFFFF))
    else $error("saturated beat without full period");

  // No compare value exceeds the period plus one.
  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.compare_u <= ({1'b0, out_o.period_count} + 17'd1)) &&
                     (out_o.compare_v <= ({1'b0, out_o.period_count} + 17'd1)) &&
                     (out_o.compare_w <= ({1'b0, out_o.period_count} + 17'd1))))
    else $error("compare value above period");

  // An accepted beat always starts the carrier computation.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == rcp_pkg::S_MUL))
    else $error("accepted beat did not start processing");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the random-carrier three-phase PWM update
// Sends update beats of three phase voltages and checks every timer setting
// beat against an in-bench model of the xorshift carrier and the compare math.
// The run covers several register settings, the extremes among them, and
// phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [rcp_pkg::CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [rcp_pkg::CFG_DATA_W-1:0]    cfg_data_t;
  typedef logic signed [rcp_pkg::VOLT_W-1:0] volt_t;

  // Register indexes above the last register; writes to them are dropped.
  localparam cfg_idx_t CFG_SPARE_FIRST = 3'd4;
  localparam cfg_idx_t CFG_SPARE_LAST  = 3'd7;

  // Idling percentages of the idling phases.
  localparam int IDLE_PCT = 55;
  localparam int BOTH_PCT = 35;

  // Cycles to watch for stray beats once everything has come back.
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic [rcp_pkg::PER_W-1:0] period_count;
    logic [rcp_pkg::CMP_W-1:0] compare_u;
    logic [rcp_pkg::CMP_W-1:0] compare_v;
    logic [rcp_pkg::CMP_W-1:0] compare_w;
    logic                      period_saturated;
  } pwm_setting_t;

  // Scoreboard: keeps its own registers and generator, works out the timer
  // setting of each accepted update beat and checks the beats that come back.
  class pwm_scoreboard;
    logic [rcp_pkg::BASE_W-1:0] base_hz;
    logic [rcp_pkg::SPAN_W-1:0] span_hz;
    logic [rcp_pkg::PSC_W-1:0]  psc_div;
    logic [rcp_pkg::CLK_W-1:0]  clock_hz;
    logic [rcp_pkg::RNG_W-1:0]  xs_x, xs_y, xs_z, xs_w;
    pwm_setting_t               pending_settings[$];
    int                         failures;

    function new();
      base_hz  = rcp_pkg::BASE_RST;
      span_hz  = rcp_pkg::SPAN_RST;
      psc_div  = rcp_pkg::PSC_RST;
      clock_hz = rcp_pkg::CLK_RST;
      xs_x     = rcp_pkg::RNG_X_RST;
      xs_y     = rcp_pkg::RNG_Y_RST;
      xs_z     = rcp_pkg::RNG_Z_RST;
      xs_w     = rcp_pkg::RNG_W_RST;
      failures = 0;
    endfunction

    // Register write; data is cut to the register width, spare indexes do nothing.
    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        rcp_pkg::CFG_BASE: base_hz  = data[rcp_pkg::BASE_W-1:0];
        rcp_pkg::CFG_SPAN: span_hz  = data[rcp_pkg::SPAN_W-1:0];
        rcp_pkg::CFG_PSC:  psc_div  = data[rcp_pkg::PSC_W-1:0];
        rcp_pkg::CFG_CLK:  clock_hz = data[rcp_pkg::CLK_W-1:0];
        default: ;
      endcase
    endfunction

    // One xorshift128 step; returns the new w word.
    function logic [rcp_pkg::RNG_W-1:0] next_word();
      logic [rcp_pkg::RNG_W-1:0] t;
      t    = xs_x ^ (xs_x << rcp_pkg::XS_A);
      xs_x = xs_y;
      xs_y = xs_z;
      xs_z = xs_w;
      xs_w = xs_w ^ (xs_w >> rcp_pkg::XS_B) ^ t ^ (t >> rcp_pkg::XS_C);
      return xs_w;
    endfunction

    // Compare value: floor((period + 1) * (1 + v) / 2) with v clamped to +-1.0.
    function logic [rcp_pkg::CMP_W-1:0] duty_compare(logic [rcp_pkg::PER_W-1:0] period,
                                                     volt_t volt);
      int               lvl;
      longint unsigned  prod;
      lvl = int'(volt);
      if (lvl > int'(rcp_pkg::VOLT_MAX)) lvl = int'(rcp_pkg::VOLT_MAX);
      if (lvl < int'(rcp_pkg::VOLT_MIN)) lvl = int'(rcp_pkg::VOLT_MIN);
      prod = (longint'(period) + 1) * longint'(lvl + int'(rcp_pkg::VOLT_OFS));
      return prod[rcp_pkg::CMP_W+14:15];
    endfunction

    // Timer setting for one update beat; advances the generator.
    function pwm_setting_t timer_setting(volt_t vu, volt_t vv, volt_t vw);
      logic [rcp_pkg::RNG_W-1:0] word;
      longint                    one_hz;
      longint                    carrier;
      longint unsigned           quot;
      longint unsigned           span2;
      longint unsigned           per;
      pwm_setting_t              res;
      word    = next_word();
      one_hz  = longint'(1) << 31;
      // Carrier scaled by 2^31, exact; floor of 1 Hz.
      carrier = longint'(base_hz) * one_hz + longint'(span_hz) * (longint'(word) - one_hz);
      if (carrier < one_hz) carrier = one_hz;
      quot  = (longint'(clock_hz) << 31) / carrier;
      span2 = longint'(2) * ((psc_div == '0) ? longint'(1) : longint'(psc_div));
      per   = quot / span2;
      res.period_saturated = (per > 65535);
      if (per > 65535) per = 65535;
      res.period_count = per[rcp_pkg::PER_W-1:0];
      res.compare_u = duty_compare(res.period_count, vu);
      res.compare_v = duty_compare(res.period_count, vv);
      res.compare_w = duty_compare(res.period_count, vw);
      return res;
    endfunction

    function void note_update(volt_t vu, volt_t vv, volt_t vw);
      pending_settings.push_back(timer_setting(vu, vv, vw));
    endfunction

    function void mismatch(string field, longint unsigned want, longint unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    endfunction

    function void check_setting(pwm_setting_t got);
      pwm_setting_t want;
      if (pending_settings.size() == 0) begin
        $display("%0t: setting beat with none expected, expected nothing, actual period %0d",
                 $time, got.period_count);
        failures++;
        return;
      end
      want = pending_settings.pop_front();
      if (got.period_count !== want.period_count)
        mismatch("period_count", 64'(want.period_count), 64'(got.period_count));
      if (got.compare_u !== want.compare_u)
        mismatch("compare_u", 64'(want.compare_u), 64'(got.compare_u));
      if (got.compare_v !== want.compare_v)
        mismatch("compare_v", 64'(want.compare_v), 64'(got.compare_v));
      if (got.compare_w !== want.compare_w)
        mismatch("compare_w", 64'(want.compare_w), 64'(got.compare_w));
      if (got.period_saturated !== want.period_saturated)
        mismatch("period_saturated", 64'(want.period_saturated), 64'(got.period_saturated));
    endfunction

    function int pending();
      return pending_settings.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  cfg_idx_t  cfg_idx_i;
  cfg_data_t cfg_data_i;

  rcp_in_if  in_if ();
  rcp_out_if out_if ();

  pwm_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  random_carrier_three_phase_pwm u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Clock, 2 ns period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Receiver: ready drops at random while stalls are enabled.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_setting(pwm_setting_t'{period_count:     out_if.period_count,
                                      compare_u:        out_if.compare_u,
                                      compare_v:        out_if.compare_v,
                                      compare_w:        out_if.compare_w,
                                      period_saturated: out_if.period_saturated});
    end
  end

  // Register write on the next edge; the caller lowers the write enable.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(input int unsigned base, input int unsigned span,
                              input int unsigned psc, input int unsigned clk,
                              input bit spare);
    write_reg(rcp_pkg::CFG_BASE, cfg_data_t'(base));
    write_reg(rcp_pkg::CFG_SPAN, cfg_data_t'(span));
    write_reg(rcp_pkg::CFG_PSC, cfg_data_t'(psc));
    write_reg(rcp_pkg::CFG_CLK, cfg_data_t'(clk));
    if (spare) begin
      write_reg(cfg_idx_t'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                cfg_data_t'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  // One update beat; valid stays high after the accepting edge so that
  // back-to-back beats need no second assignment in the same step.
  task automatic send_update(input volt_t vu, input volt_t vv, input volt_t vw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.volt_u <= vu;
    in_if.volt_v <= vv;
    in_if.volt_w <= vw;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_update(vu, vv, vw);
  endtask

  // Stop sending and wait until every expected setting has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic pick_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;        recv_stall_pct = 0;        end
      1: begin send_idle_pct = IDLE_PCT; recv_stall_pct = 0;        end
      2: begin send_idle_pct = 0;        recv_stall_pct = IDLE_PCT; end
      default: begin send_idle_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT; end
    endcase
  endtask

  // Mostly within +-1.0, sometimes anywhere in the field.
  function automatic volt_t rand_volt();
    int pick;
    pick = int'($urandom_range(9));
    if (pick < 6) return volt_t'($urandom_range(32768) - 16384);
    if (pick == 6) return $urandom_range(1) ? rcp_pkg::VOLT_MAX : rcp_pkg::VOLT_MIN;
    return volt_t'($urandom);
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_update(rand_volt(), rand_volt(), rand_volt());
      // Now and then hold off until the pipeline is empty.
      if ($urandom_range(99) == 0) wait_drained();
    end
  endtask

  // Run deadline.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Stimulus.
  initial begin
    volt_t edge_volts[12];
    edge_volts = '{-16'sd32768, -16'sd16385, -16'sd16384, -16'sd1, 16'sd0, 16'sd1,
                   16'sd16383, 16'sd16384, 16'sd16385, 16'sd32767, -16'sd8192, 16'sd8192};
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= rcp_pkg::CFG_BASE;
    cfg_data_i   <= '0;
    in_if.valid  <= 1'b0;
    in_if.volt_u <= '0;
    in_if.volt_v <= '0;
    in_if.volt_w <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Voltage extremes at the reset settings.
    for (int i = 0; i < 12; i++) begin
      send_update(edge_volts[i], edge_volts[(i + 3) % 12], edge_volts[(i + 7) % 12]);
    end
    wait_drained();

    // Fixed settings: typical, carrier below 1 Hz, zero carrier and prescaler,
    // period of zero, all-ones writes cut to width, zero clock.
    for (int phase = 0; phase < 6; phase++) begin
      pick_idling(phase);
      case (phase)
        0: apply_config(10000, 10000, 1, 72000000, 1'b0);
        1: apply_config(1, 50000, 1, 200000000, 1'b0);
        2: apply_config(0, 0, 0, 200000000, 1'b1);
        3: apply_config(100000, 50000, 65536, 1, 1'b0);
        4: apply_config('1, '1, '1, '1, 1'b1);
        default: apply_config(50000, 0, 0, 0, 1'b1);
      endcase
      if (phase == 1) begin
        for (int i = 0; i < 6; i++) begin
          send_update(edge_volts[i * 2], edge_volts[(i * 2 + 5) % 12], edge_volts[11 - i]);
        end
      end
      send_random(40);
      wait_drained();
    end

    // Random settings.
    for (int phase = 0; phase < 12; phase++) begin
      pick_idling(phase);
      apply_config(($urandom_range(4) == 0) ? $urandom_range(100) : $urandom_range(100000, 1),
                   $urandom_range(50000),
                   ($urandom_range(3) == 0) ? $urandom_range(65536, 1) : $urandom_range(64, 1),
                   $urandom_range(200000000, 1),
                   bit'($urandom_range(1)));
      send_random(80);
      wait_drained();
    end

    // Watch for stray beats, then report.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
